// ----- rtl/nconv_pkg.sv -----
//------------------------------------------------------------------------------
// nconv_pkg
// Shared types and constants of the normalized 3x3 convolution unit.
//------------------------------------------------------------------------------
`default_nettype none

package nconv_pkg;

  // Default parameter values.
  localparam int unsigned MaxWidthDef   = 4096;
  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned WeightBitsDef = 16;

  // Fixed field widths.
  localparam int unsigned WeightRegBits = 48;
  localparam int unsigned GridWBits     = 13;
  localparam int unsigned GridHBits     = 16;
  localparam int unsigned FiltBits      = 24;
  localparam int unsigned ColBits       = 12;
  localparam int unsigned RowBits       = 16;
  localparam int unsigned CfgIdxBits    = 3;
  localparam int unsigned CfgDataBits   = 48;

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] RegWeightsTop = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegWeightsMid = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegWeightsBot = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegGridWidth  = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegGridHeight = 3'd4;

  // Reset values.
  localparam logic [WeightRegBits-1:0] WeightsTopRst = 48'd4398180729856;
  localparam logic [WeightRegBits-1:0] WeightsMidRst = 48'd8800119556096;
  localparam logic [WeightRegBits-1:0] WeightsBotRst = 48'd4398180729856;
  localparam logic [GridWBits-1:0]     GridWidthRst  = 13'd640;
  localparam logic [GridHBits-1:0]     GridHeightRst = 16'd480;

  // Saturation limits of the filtered result.
  localparam logic signed [FiltBits-1:0] FiltMax = 24'sh7FFFFF;
  localparam logic signed [FiltBits-1:0] FiltMin = -24'sh800000;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic       load;      // capture an item and update line stores/window
    logic       start;     // start evaluating one result
    logic [1:0] kind;      // which window view to evaluate
    logic       emit;      // present the evaluated result
  } nconv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
  } nconv_sts_t;

  // Window views.
  localparam logic [1:0] ViewMain     = 2'd0;
  localparam logic [1:0] ViewFlush    = 2'd1;
  localparam logic [1:0] ViewLast     = 2'd2;
  localparam logic [1:0] ViewLastFlsh = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/nconv_if.sv -----
//------------------------------------------------------------------------------
// nconv_in_if / nconv_out_if / nconv_cfg_if
// Valid/ready channel interfaces of the convolution unit.
//------------------------------------------------------------------------------
`default_nettype none

interface nconv_in_if #(
  parameter int unsigned SampleBits = nconv_pkg::SampleBitsDef
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample;
  logic                         sample_missing;
  modport source (output valid, sample, sample_missing, input ready);
  modport sink   (input valid, sample, sample_missing, output ready);
endinterface

interface nconv_out_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [nconv_pkg::FiltBits-1:0]      filtered;
  logic                                       result_missing;
  logic        [nconv_pkg::ColBits-1:0]       out_column;
  logic        [nconv_pkg::RowBits-1:0]       out_row;
  logic                                       last_of_run;
  modport source (output valid, filtered, result_missing, out_column, out_row,
                  last_of_run, input ready);
  modport sink   (input valid, filtered, result_missing, out_column, out_row,
                  last_of_run, output ready);
endinterface

interface nconv_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [nconv_pkg::CfgIdxBits-1:0]      index;
  logic [nconv_pkg::CfgDataBits-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/nconv_div.sv -----
//------------------------------------------------------------------------------
// nconv_div
// Restoring divider, one quotient bit per cycle, on magnitudes.
//------------------------------------------------------------------------------
`default_nettype none

module nconv_div #(
  parameter int unsigned NumBits = 48,
  parameter int unsigned DenBits = 20
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [NumBits-1:0] num_i,
  input  wire logic [DenBits-1:0] den_i,
  output logic                    done_o,
  output logic [NumBits-1:0]      quot_o
);
  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] quot_q, quot_d;
  logic [DenBits:0]   rem_q, rem_d;
  logic [DenBits-1:0] den_q;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DenBits:0]   trial;

  // One shift-subtract step per cycle.
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenBits-1:0], quot_q[NumBits-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      cnt_d  = CntBits'(NumBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

`default_nettype wire

// ----- rtl/nconv_datapath.sv -----
//------------------------------------------------------------------------------
// nconv_datapath
// Line stores, 3x3 window, position counters, accumulation and division.
//------------------------------------------------------------------------------
`default_nettype none

module nconv_datapath #(
  parameter int unsigned MaxWidth   = nconv_pkg::MaxWidthDef,
  parameter int unsigned SampleBits = nconv_pkg::SampleBitsDef,
  parameter int unsigned WeightBits = nconv_pkg::WeightBitsDef
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire nconv_pkg::nconv_cmd_t                  cmd_i,
  output nconv_pkg::nconv_sts_t                       sts_o,
  input  wire logic signed [SampleBits-1:0]           sample_i,
  input  wire logic                                   missing_i,
  input  wire logic [nconv_pkg::WeightRegBits-1:0]    w_top_i,
  input  wire logic [nconv_pkg::WeightRegBits-1:0]    w_mid_i,
  input  wire logic [nconv_pkg::WeightRegBits-1:0]    w_bot_i,
  input  wire logic [nconv_pkg::GridWBits-1:0]        grid_w_i,
  input  wire logic [nconv_pkg::GridHBits-1:0]        grid_h_i,
  output logic [3:0]                                  plan_o,
  output logic signed [nconv_pkg::FiltBits-1:0]       filtered_o,
  output logic                                        missing_o,
  output logic [nconv_pkg::ColBits-1:0]               col_o,
  output logic [nconv_pkg::RowBits-1:0]               row_o
);
  localparam int unsigned AddrBits = $clog2(MaxWidth);
  localparam int unsigned CellBits = SampleBits + 1;
  localparam int unsigned ProdBits = SampleBits + WeightBits;
  localparam int unsigned SumBits  = ProdBits + 4;
  localparam int unsigned NsumBits = WeightBits + 4;
  localparam int unsigned NumBits  = SumBits + 8;
  localparam int unsigned WidthBits = AddrBits + 1;
  localparam int unsigned RB = nconv_pkg::RowBits;

  typedef struct packed {
    logic                         ok;
    logic signed [SampleBits-1:0] v;
  } cell_t;

  // Line stores, one write and one registered read each.
  cell_t mem_up [MaxWidth];
  cell_t mem_lo [MaxWidth];

  cell_t win_q [3][3];
  cell_t cur_q, rd_up_q, rd_lo_q;
  logic [AddrBits-1:0] c_q;
  logic [RB-1:0]       r_q;
  logic                last_col_q, last_row_q, c0_q;
  logic [AddrBits-1:0] col_cnt_q;
  logic [RB-1:0]       row_cnt_q;
  logic                upd_q;

  // Effective size and clamped position.
  logic [WidthBits-1:0] w_eff;
  logic [RB-1:0]        h_eff;
  logic [AddrBits-1:0]  c_now;
  logic [RB-1:0]        r_now;
  always_comb begin
    if (grid_w_i == '0) begin
      w_eff = WidthBits'(1);
    end else if (32'(grid_w_i) > MaxWidth) begin
      w_eff = WidthBits'(MaxWidth);
    end else begin
      w_eff = WidthBits'(grid_w_i);
    end
    h_eff = (grid_h_i == '0) ? RB'(1) : grid_h_i;
    c_now = ({1'b0, col_cnt_q} >= w_eff) ? AddrBits'(w_eff - 1'b1) : col_cnt_q;
    r_now = (row_cnt_q >= h_eff) ? h_eff - 1'b1 : row_cnt_q;
  end

  // Capture an item: read line stores, then update window in the following cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_up_q <= mem_up[c_now];
      rd_lo_q <= mem_lo[c_now];
      cur_q <= '{ok: !missing_i, v: sample_i};
      c_q <= c_now;
      r_q <= r_now;
      last_col_q <= (c_now == AddrBits'(w_eff - 1'b1));
      last_row_q <= (r_now == h_eff - 1'b1);
      c0_q <= (c_now == '0);
      mem_lo[c_now] <= '{ok: !missing_i, v: sample_i};
    end
    if (upd_q) begin
      mem_up[c_q] <= rd_lo_q;
    end
  end

  // Position counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      upd_q <= 1'b0;
    end else begin
      upd_q <= cmd_i.load;
      if (cmd_i.load) begin
        if (c_now == AddrBits'(w_eff - 1'b1)) begin
          col_cnt_q <= '0;
          row_cnt_q <= (r_now == h_eff - 1'b1) ? '0 : r_now + 1'b1;
        end else begin
          col_cnt_q <= c_now + 1'b1;
          row_cnt_q <= r_now;
        end
      end
    end
  end

  // Window shift.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (upd_q) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= c0_q ? '0 : win_q[i][1];
        win_q[i][1] <= c0_q ? '0 : win_q[i][2];
      end
      win_q[0][2] <= (r_q >= RB'(2)) ? rd_up_q : '0;
      win_q[1][2] <= (r_q >= RB'(1)) ? rd_lo_q : '0;
      win_q[2][2] <= cur_q;
    end
  end

  // Which results this item produces: main, flush, last-row main, last-row flush.
  assign plan_o = {last_row_q && last_col_q, last_row_q && !c0_q,
                   (r_q != '0) && last_col_q, (r_q != '0) && !c0_q};

  // Selected view of the window.
  cell_t view [3][3];
  logic [1:0] kind_q;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        view[i][j] = win_q[i][j];
      end
    end
    if (kind_q[0]) begin
      for (int i = 0; i < 3; i++) begin
        view[i][0] = win_q[i][1];
        view[i][1] = win_q[i][2];
        view[i][2] = '0;
      end
    end
    if (kind_q[1]) begin
      for (int j = 0; j < 3; j++) begin
        view[0][j] = view[1][j];
        view[1][j] = view[2][j];
        view[2][j] = '0;
      end
    end
  end

  // Serial multiply-accumulate over nine taps.
  logic [3:0] tap_q;
  logic       mac_q;
  logic signed [SumBits-1:0]  sum_q;
  logic [NsumBits-1:0]        nsum_q;
  logic signed [ProdBits-1:0] prod_q;
  logic [NsumBits-1:0]        mag_q;
  logic                       prod_v_q;
  logic [1:0] ti, tj;
  logic [nconv_pkg::WeightRegBits-1:0] wreg;
  logic signed [WeightBits-1:0] wt;
  cell_t tc;
  logic div_start_q;
  logic signed [SumBits-1:0] sum_fin_q;
  logic [NsumBits-1:0]       nsum_fin_q;

  // Tap number to window row and column.
  always_comb begin
    ti = 2'd0;
    tj = tap_q[1:0];
    if (tap_q >= 4'd6) begin
      ti = 2'd2;
      tj = 2'(tap_q - 4'd6);
    end else if (tap_q >= 4'd3) begin
      ti = 2'd1;
      tj = 2'(tap_q - 4'd3);
    end
    case (ti)
      2'd0:    wreg = w_top_i;
      2'd1:    wreg = w_mid_i;
      default: wreg = w_bot_i;
    endcase
    wt = wreg[tj*WeightBits +: WeightBits];
    tc = view[ti][tj];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
      mac_q <= 1'b0;
      prod_v_q <= 1'b0;
      div_start_q <= 1'b0;
      kind_q <= '0;
    end else begin
      div_start_q <= 1'b0;
      if (cmd_i.start) begin
        kind_q <= cmd_i.kind;
        tap_q <= '0;
        mac_q <= 1'b1;
      end else if (mac_q) begin
        tap_q <= tap_q + 1'b1;
        if (tap_q == 4'd8) begin
          mac_q <= 1'b0;
        end
      end
      prod_v_q <= mac_q;
      if (prod_v_q && !mac_q) begin
        div_start_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      sum_q  <= '0;
      nsum_q <= '0;
    end else if (prod_v_q) begin
      sum_q  <= sum_q + SumBits'(prod_q);
      nsum_q <= nsum_q + mag_q;
    end
    if (mac_q) begin
      prod_q <= tc.ok ? ProdBits'(wt * tc.v) : ProdBits'(0);
      mag_q  <= tc.ok ? NsumBits'(wt < 0 ? -wt : wt) : '0;
      if (tc.ok && wt == {1'b1, {(WeightBits-1){1'b0}}}) begin
        mag_q <= NsumBits'({1'b1, {(WeightBits-1){1'b0}}});
      end
    end
    if (prod_v_q && !mac_q) begin
      sum_fin_q  <= sum_q + SumBits'(prod_q);
      nsum_fin_q <= nsum_q + mag_q;
    end
  end

  // Divide |sum|*256 by nsum: truncation toward zero of the scaled quotient.
  logic [NumBits-1:0] num_abs, quot;
  logic               div_done;
  assign num_abs = sum_fin_q[SumBits-1] ? NumBits'(-sum_fin_q) << 8
                                        : NumBits'(sum_fin_q) << 8;
  nconv_div #(.NumBits(NumBits), .DenBits(NsumBits)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (num_abs),
    .den_i   (nsum_fin_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );
  assign sts_o.div_done = div_done;

  // Sign, saturation and result fields.
  logic signed [NumBits:0] sval;
  always_comb begin
    sval = sum_fin_q[SumBits-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  end

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      missing_o <= (nsum_fin_q == '0);
      if (nsum_fin_q == '0) begin
        filtered_o <= '0;
      end else if (sval > (NumBits+1)'(nconv_pkg::FiltMax)) begin
        filtered_o <= nconv_pkg::FiltMax;
      end else if (sval < (NumBits+1)'(nconv_pkg::FiltMin)) begin
        filtered_o <= nconv_pkg::FiltMin;
      end else begin
        filtered_o <= nconv_pkg::FiltBits'(sval);
      end
      col_o <= nconv_pkg::ColBits'(kind_q[0] ? c_q : c_q - 1'b1);
      row_o <= kind_q[1] ? r_q : r_q - 1'b1;
    end
  end
endmodule

`default_nettype wire

// ----- rtl/nconv_ctrl.sv -----
//------------------------------------------------------------------------------
// nconv_ctrl
// Sequencer: accepts an item, walks its results, drives output handshake.
//------------------------------------------------------------------------------
`default_nettype none

module nconv_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       last_o,
  output nconv_pkg::nconv_cmd_t      cmd_o,
  input  wire nconv_pkg::nconv_sts_t sts_i,
  input  wire logic [3:0]            plan_i
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StPick = 3'd2;
  localparam logic [2:0] StCalc = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [3:0] todo_q, todo_d;
  logic [1:0] pick;
  logic [3:0] rest;

  // Lowest pending result and what remains after it.
  always_comb begin
    pick = 2'd0;
    if (todo_q[0]) begin
      pick = 2'd0;
    end else if (todo_q[1]) begin
      pick = 2'd1;
    end else if (todo_q[2]) begin
      pick = 2'd2;
    end else begin
      pick = 2'd3;
    end
    rest = todo_q & ~(4'b0001 << pick);
  end

  always_comb begin
    state_d = state_q;
    todo_d  = todo_q;
    cmd_o   = '0;
    in_ready_o = (state_q == StIdle);
    out_valid_o = (state_q == StOut);
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = StRead;
        end
      end
      StRead: begin
        todo_d  = plan_i;
        state_d = StPick;
      end
      StPick: begin
        if (todo_q == '0) begin
          state_d = StIdle;
        end else begin
          cmd_o.start = 1'b1;
          cmd_o.kind  = pick;
          state_d = StCalc;
        end
      end
      StCalc: begin
        if (sts_i.div_done) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_ready_i) begin
          todo_d = rest;
          state_d = (rest == '0) ? StIdle : StPick;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign last_o = (rest == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      todo_q  <= '0;
    end else begin
      state_q <= state_d;
      todo_q  <= todo_d;
    end
  end
endmodule

`default_nettype wire

// ----- rtl/normalized_3x3_convolution_unit.sv -----
// Flow: a new cell is accepted only once every result of the previous cell
//   has been taken; the nine-tap serial accumulate and the bit-per-cycle
//   divider set the time taken per result.
// Reset: asynchronous, active low; window cleared, counters zero, line stores
//   left unwritten.
//------------------------------------------------------------------------------
// normalized_3x3_convolution_unit
// Top level: configuration registers, controller and datapath.
//------------------------------------------------------------------------------
`default_nettype none

module normalized_3x3_convolution_unit #(
  parameter int unsigned MaxWidth   = nconv_pkg::MaxWidthDef,
  parameter int unsigned SampleBits = nconv_pkg::SampleBitsDef,
  parameter int unsigned WeightBits = nconv_pkg::WeightBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  nconv_in_if.sink  in_if,
  nconv_out_if.source out_if,
  nconv_cfg_if.sink cfg_if
);
  logic [nconv_pkg::WeightRegBits-1:0] w_top_q, w_mid_q, w_bot_q;
  logic [nconv_pkg::GridWBits-1:0]     grid_w_q;
  logic [nconv_pkg::GridHBits-1:0]     grid_h_q;

  // Configuration writes.
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_top_q  <= nconv_pkg::WeightsTopRst;
      w_mid_q  <= nconv_pkg::WeightsMidRst;
      w_bot_q  <= nconv_pkg::WeightsBotRst;
      grid_w_q <= nconv_pkg::GridWidthRst;
      grid_h_q <= nconv_pkg::GridHeightRst;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        nconv_pkg::RegWeightsTop: w_top_q <= cfg_if.data;
        nconv_pkg::RegWeightsMid: w_mid_q <= cfg_if.data;
        nconv_pkg::RegWeightsBot: w_bot_q <= cfg_if.data;
        nconv_pkg::RegGridWidth:  grid_w_q <= cfg_if.data[nconv_pkg::GridWBits-1:0];
        nconv_pkg::RegGridHeight: grid_h_q <= cfg_if.data[nconv_pkg::GridHBits-1:0];
        default: ;
      endcase
    end
  end

  nconv_pkg::nconv_cmd_t cmd;
  nconv_pkg::nconv_sts_t sts;
  logic [3:0] plan;

  nconv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .last_o      (out_if.last_of_run),
    .cmd_o       (cmd),
    .sts_i       (sts),
    .plan_i      (plan)
  );

  nconv_datapath #(
    .MaxWidth(MaxWidth), .SampleBits(SampleBits), .WeightBits(WeightBits)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .sample_i   (in_if.sample),
    .missing_i  (in_if.sample_missing),
    .w_top_i    (w_top_q),
    .w_mid_i    (w_mid_q),
    .w_bot_i    (w_bot_q),
    .grid_w_i   (grid_w_q),
    .grid_h_i   (grid_h_q),
    .plan_o     (plan),
    .filtered_o (out_if.filtered),
    .missing_o  (out_if.result_missing),
    .col_o      (out_if.out_column),
    .row_o      (out_if.out_row)
  );
endmodule

`default_nettype wire

// ----- rtl/nconv_checker.sv -----
//------------------------------------------------------------------------------
// nconv_checker
// Port-level checks of the convolution unit, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module nconv_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_missing,
  input wire logic signed [nconv_pkg::FiltBits-1:0] out_filtered
);
  // A waiting result holds until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered))
    else $error("result dropped while stalled");

  // A missing result carries zero.
  a_missing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_missing |-> out_filtered == '0)
    else $error("missing result not zero");

  // No new item while a result is pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("input accepted while result pending");

  // After an accept the input side closes for the next cycle.
  a_accept_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("back-to-back accept");
endmodule

bind normalized_3x3_convolution_unit nconv_checker u_nconv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_missing  (out_if.result_missing),
  .out_filtered (out_if.filtered)
);

`default_nettype wire
